/* hw/rtl/framed_message_serializer_core_defines.svh */
// assertion macros shared by the serializer checker
`ifndef FRAMED_MESSAGE_SERIALIZER_CORE_DEFINES_SVH
`define FRAMED_MESSAGE_SERIALIZER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fms_pkg.sv */
`default_nettype none

package fms_pkg;

    // request field widths
    localparam int FUNC_W = 2;
    localparam int ADDR_W = 14;
    localparam int GAP_W  = 8;

    // default address width kept by a start request
    localparam int ADDRESS_BITS_DEF = 14;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

    // framing
    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [3:0] STOP_POS   = 4'd9;
    localparam logic [1:0] LAST_BYTE  = 2'd3;

    localparam logic [GAP_W-1:0] GAP_RESET = 8'd10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic line_level;
        logic message_end;
    } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/framed_message_serializer_core.sv */
// framed message serializer
// request channel: req_valid / req_stall / req_data carry a func code and an
// address. tick requests each send one bit time; start loads the message
// (sync 0x55, address high, address low, xor checksum) when not already
// sending; stop halts sending. only a tick produces a response.
// response channel: rsp_valid / rsp_stall / rsp_data carry the inverted pin
// level and a flag on the checksum byte's stop bit.
// gap_bits is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while idle, the block itself does not enforce this.
// throughput: one request per cycle, except while a tick waits on a stalled
// response; the response register is loaded straight from the request register.
// reset: not sending, counters cleared, gap_bits = 10, both stages empty.
// stall: a stalled response holds; the request register keeps taking
// requests while it can pass them on, then raises req_stall.
`default_nettype none

module framed_message_serializer_core #(
    parameter int ADDRESS_BITS = fms_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [fms_pkg::GAP_W-1:0]  cfg_wr_data,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire fms_pkg::req_t              req_data,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output fms_pkg::rsp_t                   rsp_data
);

    // address bits kept from a start request
    localparam int KeepBits = (ADDRESS_BITS < fms_pkg::ADDR_W) ? ADDRESS_BITS : fms_pkg::ADDR_W;
    localparam logic [fms_pkg::ADDR_W-1:0] AddrMask =
        {fms_pkg::ADDR_W{1'b1}} >> (fms_pkg::ADDR_W - KeepBits);

    // request stage
    logic          req_valid_reg, req_valid_next;
    fms_pkg::req_t req_reg;

    // response stage
    logic          rsp_valid_reg, rsp_valid_next;
    fms_pkg::rsp_t rsp_reg, rsp_next;

    // sender state
    logic                      sending_reg, sending_next;
    logic [1:0]                byte_pos_reg, byte_pos_next;
    logic [3:0]                bit_pos_reg, bit_pos_next;
    logic [fms_pkg::GAP_W-1:0] gap_rem_reg, gap_rem_next;
    logic [fms_pkg::GAP_W-1:0] gap_bits_reg;

    // message bytes, sync byte is a constant
    logic [7:0] hi_reg, hi_next;
    logic [7:0] lo_reg, lo_next;
    logic [7:0] chk_reg, chk_next;

    logic                      is_tick;
    logic                      advance;
    logic                      take;
    logic [fms_pkg::ADDR_W-1:0] addr_masked;
    logic [7:0]                cur_byte;
    logic [3:0]                bit_idx;
    logic [3:0]                bit_pos_inc;
    logic                      cur_bit;
    logic                      last_bit;

    assign is_tick   = (req_reg.func == fms_pkg::FUNC_TICK);
    // a tick needs room in the response stage, other requests never wait
    assign advance   = req_valid_reg && (!is_tick || !rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign addr_masked = req_reg.address & AddrMask;

    // byte on the line
    always_comb
    begin
        unique case (byte_pos_reg)
            2'd0:    cur_byte = fms_pkg::SYNC_BYTE;
            2'd1:    cur_byte = hi_reg;
            2'd2:    cur_byte = lo_reg;
            default: cur_byte = chk_reg;
        endcase
    end

    assign bit_idx     = bit_pos_reg - 4'd1;
    assign bit_pos_inc = bit_pos_reg + 4'd1;
    assign last_bit    = (byte_pos_reg == fms_pkg::LAST_BYTE) && (bit_pos_reg >= fms_pkg::STOP_POS);

    // logical bit: start bit low, data lsb first, stop bit high
    always_comb
    begin
        priority if (bit_pos_reg == 4'd0)
        begin
            cur_bit = 1'b0;
        end
        else if (bit_pos_reg >= fms_pkg::STOP_POS)
        begin
            cur_bit = 1'b1;
        end
        else
        begin
            cur_bit = cur_byte[bit_idx[2:0]];
        end
    end

    // next state for the request leaving the request stage
    always_comb
    begin
        sending_next  = sending_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        gap_rem_next  = gap_rem_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        chk_next      = chk_reg;
        rsp_next      = rsp_reg;

        // response stage empties when taken
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (advance)
        begin
            unique case (req_reg.func)
                fms_pkg::FUNC_START:
                begin
                    // ignored while a message is going out
                    if (!sending_reg)
                    begin
                        hi_next       = 8'(addr_masked >> 8);
                        lo_next       = addr_masked[7:0];
                        chk_next      = fms_pkg::SYNC_BYTE ^ 8'(addr_masked >> 8)
                                        ^ addr_masked[7:0];
                        byte_pos_next = 2'd0;
                        bit_pos_next  = 4'd0;
                        gap_rem_next  = '0;
                        sending_next  = 1'b1;
                    end
                end
                fms_pkg::FUNC_STOP:
                begin
                    sending_next = 1'b0;
                end
                fms_pkg::FUNC_TICK:
                begin
                    rsp_valid_next = 1'b1;
                    if (!sending_reg)
                    begin
                        // idle line
                        rsp_next.line_level  = 1'b0;
                        rsp_next.message_end = 1'b0;
                    end
                    else if (gap_rem_reg != '0)
                    begin
                        // inter-message gap
                        gap_rem_next         = gap_rem_reg - 1'b1;
                        rsp_next.line_level  = 1'b0;
                        rsp_next.message_end = 1'b0;
                    end
                    else
                    begin
                        // pin is inverted
                        rsp_next.line_level  = !cur_bit;
                        rsp_next.message_end = last_bit;
                        if (bit_pos_inc >= fms_pkg::FRAME_BITS)
                        begin
                            bit_pos_next = 4'd0;
                            if (byte_pos_reg == fms_pkg::LAST_BYTE)
                            begin
                                byte_pos_next = 2'd0;
                                gap_rem_next  = gap_bits_reg;
                            end
                            else
                            begin
                                byte_pos_next = byte_pos_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_inc;
                        end
                    end
                end
                default:
                begin
                    // unused code, dropped
                end
            endcase
        end

        // request stage fills on accept, empties on advance
        if (take)
        begin
            req_valid_next = 1'b1;
        end
        else
        begin
            req_valid_next = req_valid_reg && !advance;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            sending_reg   <= 1'b0;
            byte_pos_reg  <= 2'd0;
            bit_pos_reg   <= 4'd0;
            gap_rem_reg   <= '0;
            gap_bits_reg  <= fms_pkg::GAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            sending_reg   <= sending_next;
            byte_pos_reg  <= byte_pos_next;
            bit_pos_reg   <= bit_pos_next;
            gap_rem_reg   <= gap_rem_next;
            if (cfg_wr_en)
            begin
                gap_bits_reg <= cfg_wr_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_data;
        end
        rsp_reg <= rsp_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        chk_reg <= chk_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/fms_checker.sv */
`default_nettype none

`include "framed_message_serializer_core_defines.svh"

module fms_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_stall,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_stall,
    input wire fms_pkg::rsp_t             rsp_data
);

    // stalled response holds
    `FMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

    // checksum stop bit is a logical one, so the pin is low
    `FMS_ASSERT_NOW(a_end_level, rsp_valid && rsp_data.message_end, !rsp_data.line_level, "message end without stop level")

    // two message ends never follow each other
    `FMS_ASSERT_NEXT(a_end_spacing, rsp_valid && !rsp_stall && rsp_data.message_end, !(rsp_valid && rsp_data.message_end), "back to back message ends")

    // a fresh response comes from a request that was taken and held in the request register
    `FMS_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "response without request")

endmodule

bind framed_message_serializer_core fms_checker u_fms_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fms_pkg::*;

    localparam int CLK_HALF_NS = 2;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_REQUESTS = 90;
    localparam int PHASES = 6;
    localparam int QUIET_PHASE = 4;
    localparam int IDLE_PCT = 30;
    localparam int MAX_REPORTS = 10;
    localparam int PLAN_ROWS = 25;
    localparam int ADDR_KEEP = ADDRESS_BITS_DEF;
    localparam int TIMEOUT_NS = 2_000_000;

    // func code with no meaning, the block drops it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        req_t request;
        logic fixed;
        rsp_t pin;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [GAP_W-1:0] cfg_wr_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    // typed-in expectation traveling with the request on the bus
    logic req_fixed = 1'b0;
    rsp_t req_pin = '0;

    // mirror of the serializer state
    logic [GAP_W-1:0] gap_setting = GAP_RESET;
    logic [7:0] frame_bytes [4];
    logic [1:0] byte_idx = '0;
    logic [3:0] bit_idx = '0;
    logic [GAP_W-1:0] gap_left = '0;
    logic active = 1'b0;

    rsp_t pending_pins [$];
    int send_idle_pct = IDLE_PCT;
    int rsp_idle_pct = IDLE_PCT;
    int miss_count = 0;
    int requests_taken = 0;
    int pins_seen = 0;
    int ends_seen = 0;
    plan_row_t plan [PLAN_ROWS];

    framed_message_serializer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // pin level for one request; returns 1 when a tick produces a response
    function automatic bit advance_line(input req_t r, output rsp_t pin);
        logic [15:0] kept;
        logic [7:0] cur;
        logic bit_val;
        pin = '0;
        kept = 16'(r.address) & 16'((32'd1 << ADDR_KEEP) - 1);
        case (r.func)
            FUNC_START:
            begin
                // a start while already sending is dropped
                if (!active)
                begin
                    frame_bytes[0] = SYNC_BYTE;
                    frame_bytes[1] = kept[15:8];
                    frame_bytes[2] = kept[7:0];
                    frame_bytes[3] = SYNC_BYTE ^ kept[15:8] ^ kept[7:0];
                    byte_idx = '0;
                    bit_idx = '0;
                    gap_left = '0;
                    active = 1'b1;
                end
                return 1'b0;
            end
            FUNC_STOP:
            begin
                active = 1'b0;
                return 1'b0;
            end
            FUNC_TICK: ;
            default: return 1'b0;
        endcase
        // idle line reads as logical 1, pin 0
        if (!active)
            return 1'b1;
        if (gap_left != '0)
        begin
            gap_left = gap_left - 1'b1;
            return 1'b1;
        end
        cur = frame_bytes[byte_idx];
        if (bit_idx == 4'd0)
            bit_val = 1'b0;
        else if (bit_idx >= STOP_POS)
            bit_val = 1'b1;
        else
            bit_val = cur[bit_idx - 1];
        pin.line_level = ~bit_val;
        pin.message_end = (byte_idx == LAST_BYTE) && (bit_idx >= STOP_POS);
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= FRAME_BITS)
        begin
            bit_idx = '0;
            if (byte_idx >= LAST_BYTE)
            begin
                byte_idx = '0;
                gap_left = gap_setting;
            end
            else
                byte_idx = byte_idx + 2'd1;
        end
        return 1'b1;
    endfunction

    function automatic plan_row_t row(input logic [FUNC_W-1:0] func,
                                      input logic [ADDR_W-1:0] address,
                                      input logic fixed,
                                      input logic level,
                                      input logic last);
        row.request.func = func;
        row.request.address = address;
        row.fixed = fixed;
        row.pin.line_level = level;
        row.pin.message_end = last;
    endfunction

    task automatic note_miss(input string what, input logic want_bit, input logic got_bit);
        miss_count++;
        if (miss_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %b, got %b", $time, what, want_bit, got_bit);
    endtask

    // responses checked against the oldest expectation, requests fed to the mirror
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t guess;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                pins_seen++;
                if (rsp_data.message_end)
                    ends_seen++;
                if (pending_pins.size() == 0)
                    note_miss("unexpected response line_level", 1'bx, rsp_data.line_level);
                else
                begin
                    want = pending_pins.pop_front();
                    if (want.line_level !== rsp_data.line_level)
                        note_miss("line_level", want.line_level, rsp_data.line_level);
                    if (want.message_end !== rsp_data.message_end)
                        note_miss("message_end", want.message_end, rsp_data.message_end);
                end
            end
            if (req_valid && !req_stall)
            begin
                requests_taken++;
                if (advance_line(req_data, guess))
                    pending_pins.push_back(req_fixed ? req_pin : guess);
            end
        end
    end

    always @(posedge clk)
        rsp_stall <= rst_n && ($urandom_range(99) < rsp_idle_pct);

    task automatic send_req(input logic [FUNC_W-1:0] func,
                            input logic [ADDR_W-1:0] address,
                            input logic fixed = 1'b0,
                            input rsp_t pin = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data.func <= func;
        req_data.address <= address;
        req_fixed <= fixed;
        req_pin <= pin;
        do @(posedge clk); while (req_stall);
    endtask

    // hold off until every response is back, then let the pipe empty
    task automatic drain_and_settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_pins.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_gap(input logic [GAP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        gap_setting = value;
        cfg_wr_en <= 1'b0;
    endtask

    // mostly start + tick runs, with stray starts, unused codes and stops mixed in
    task automatic run_traffic(input int budget);
        int done;
        int len;
        int roll;
        logic [ADDR_W-1:0] addr;
        done = 0;
        while (done < budget)
        begin
            roll = $urandom_range(9);
            addr = (roll == 0) ? '0 : (roll == 1) ? '1 : ADDR_W'($urandom);
            send_req(FUNC_START, addr);
            done++;
            len = $urandom_range(12, 120);
            for (int k = 0; k < len && done < budget; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    send_req(FUNC_START, ADDR_W'($urandom));
                else if (roll < 5)
                    send_req(FUNC_UNUSED, ADDR_W'($urandom));
                else
                begin
                    send_req(FUNC_TICK, ADDR_W'($urandom));
                    done++;
                end
            end
            if ($urandom_range(3) != 0)
            begin
                send_req(FUNC_STOP, ADDR_W'($urandom));
                done++;
            end
            repeat ($urandom_range(3))
            begin
                send_req($urandom_range(1) ? FUNC_TICK : FUNC_STOP, ADDR_W'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        logic [GAP_W-1:0] next_gap;

        // directed requests, gap still at its reset value
        plan[0] = row(FUNC_TICK, 14'h0000, 1'b1, 1'b0, 1'b0);
        plan[1] = row(FUNC_STOP, 14'h3FFF, 1'b0, 1'b0, 1'b0);
        plan[2] = row(FUNC_UNUSED, 14'h2AAA, 1'b0, 1'b0, 1'b0);
        plan[3] = row(FUNC_TICK, 14'h1555, 1'b1, 1'b0, 1'b0);
        plan[4] = row(FUNC_START, 14'h3FFF, 1'b0, 1'b0, 1'b0);
        plan[5] = row(FUNC_TICK, 14'h0000, 1'b1, 1'b1, 1'b0);
        plan[6] = row(FUNC_START, 14'h0000, 1'b0, 1'b0, 1'b0);
        for (int i = 7; i <= 16; i++)
            plan[i] = row(FUNC_TICK, ADDR_W'(i * 14'h0555), 1'b0, 1'b0, 1'b0);
        plan[17] = row(FUNC_STOP, 14'h0000, 1'b0, 1'b0, 1'b0);
        plan[18] = row(FUNC_TICK, 14'h3FFF, 1'b1, 1'b0, 1'b0);
        plan[19] = row(FUNC_START, 14'h0000, 1'b0, 1'b0, 1'b0);
        plan[20] = row(FUNC_TICK, 14'h2AAA, 1'b1, 1'b1, 1'b0);
        plan[21] = row(FUNC_UNUSED, 14'h3FFF, 1'b0, 1'b0, 1'b0);
        plan[22] = row(FUNC_STOP, 14'h1555, 1'b0, 1'b0, 1'b0);
        plan[23] = row(FUNC_STOP, 14'h3FFF, 1'b0, 1'b0, 1'b0);
        plan[24] = row(FUNC_TICK, 14'h3FFF, 1'b1, 1'b0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            send_req(plan[i].request.func, plan[i].request.address, plan[i].fixed, plan[i].pin);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_and_settle();
            case (p)
                0: next_gap = '0;
                1: next_gap = 8'd1;
                2: next_gap = '1;
                3: next_gap = GAP_W'($urandom_range(2, 24));
                4: next_gap = GAP_RESET;
                default: next_gap = GAP_W'($urandom);
            endcase
            set_gap(next_gap);
            // one phase runs back to back on both sides
            send_idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            rsp_idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            run_traffic(PHASE_REQUESTS);
        end
        drain_and_settle();

        $display("run took %0d requests and checked %0d pin samples, %0d of them message ends",
                 requests_taken, pins_seen, ends_seen);
        $display("gap lengths 0, 1, 255, 10 and random, with and without idling on both sides");
        if (miss_count == 0 && pending_pins.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule
